FILE: sv/mai8q_pkg.sv
// ----------------------------------------------------------------------------
// Max-abs int8 quantizer package
// Shared constants, the per-result tag that travels down the pipeline, and
// width helpers for the sample buffer.
// ----------------------------------------------------------------------------
package mai8q_pkg;

    // Default configuration of the block.
    localparam int DEF_BUFFER_DEPTH = 64;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Full-scale code of the int8 result and the quotient width that holds it.
    localparam int QUANT_SCALE = 127;
    localparam int QUOT_W      = 7;
    localparam int QOUT_W      = 8;

    // Side information that follows one result through the divider.
    typedef struct packed {
        logic neg;   // sample was negative
        logic last;  // final result of the burst
        logic ovf;   // samples of this burst were dropped
        logic zero;  // peak of this burst is zero
    } div_tag_t;

    // Address width of a buffer with the given number of entries.
    function automatic int idx_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Width of a counter that can hold the number of entries itself.
    function automatic int cnt_width(input int depth);
        return $clog2(depth + 1);
    endfunction

endpackage

FILE: sv/mai8q_buffer.sv
// ----------------------------------------------------------------------------
// Sample buffer
// Single-port-write, single-port-read synchronous memory with a registered
// read port. Read data appears in the cycle after the read enable.
// ----------------------------------------------------------------------------
module mai8q_buffer
    import mai8q_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [idx_width(BUFFER_DEPTH)-1:0]  wr_addr,
    input  logic [SAMPLE_WIDTH-1:0]             wr_data,
    input  logic                                rd_en,
    input  logic [idx_width(BUFFER_DEPTH)-1:0]  rd_addr,
    output logic [SAMPLE_WIDTH-1:0]             rd_data
);

    logic [SAMPLE_WIDTH-1:0] mem [BUFFER_DEPTH];
    logic [SAMPLE_WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/mai8q_divider.sv
// ----------------------------------------------------------------------------
// Pipelined quotient unit
// Restoring division with one quotient bit per stage. The quotient is known
// to stay below 2^QUOT_W, so only QUOT_W stages are needed. The whole
// pipeline advances together when adv is high.
// ----------------------------------------------------------------------------
module mai8q_divider
    import mai8q_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic [SAMPLE_WIDTH+QUOT_W-1:0] in_num,
    input  logic [SAMPLE_WIDTH-1:0]        in_peak,
    input  div_tag_t                       in_tag,
    output logic                           out_valid,
    output logic [QUOT_W-1:0]              out_quot,
    output div_tag_t                       out_tag
);

    localparam int NUM_W = SAMPLE_WIDTH + QUOT_W;

    logic                    vld_reg [QUOT_W];
    logic [NUM_W-1:0]        rem_reg [QUOT_W];
    logic [SAMPLE_WIDTH-1:0] pk_reg  [QUOT_W];
    logic [QUOT_W-1:0]       q_reg   [QUOT_W];
    div_tag_t                tag_reg [QUOT_W];

    for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
        // Stage j decides quotient bit QUOT_W-1-j against 2*peak shifted up.
        localparam int SHIFT = QUOT_W - j;

        logic                    vld_in;
        logic [NUM_W-1:0]        rem_in;
        logic [SAMPLE_WIDTH-1:0] pk_in;
        logic [QUOT_W-1:0]       q_in;
        div_tag_t                tag_in;
        logic [NUM_W-1:0]        trial;

        if (j == 0) begin : g_first
            assign vld_in = in_valid;
            assign rem_in = in_num;
            assign pk_in  = in_peak;
            assign q_in   = '0;
            assign tag_in = in_tag;
        end else begin : g_next
            assign vld_in = vld_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign pk_in  = pk_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign tag_in = tag_reg[j-1];
        end

        assign trial = NUM_W'(pk_in) << SHIFT;

        // Valid bit of the stage.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (adv) begin
                vld_reg[j] <= vld_in;
            end
        end

        // Trial subtraction; the remainder is kept only when it fits.
        always_ff @(posedge aclk) begin
            if (adv) begin
                pk_reg[j]  <= pk_in;
                tag_reg[j] <= tag_in;
                if (rem_in >= trial) begin
                    rem_reg[j] <= rem_in - trial;
                    q_reg[j]   <= q_in | (QUOT_W'(1) << (SHIFT - 1));
                end else begin
                    rem_reg[j] <= rem_in;
                    q_reg[j]   <= q_in;
                end
            end
        end
    end

    assign out_valid = vld_reg[QUOT_W-1];
    assign out_quot  = q_reg[QUOT_W-1];
    assign out_tag   = tag_reg[QUOT_W-1];

endmodule

FILE: sv/max_abs_int8_quantizer.sv
// ----------------------------------------------------------------------------
// Max-abs int8 quantizer
// Buffers a burst of signed samples, tracks their peak magnitude, and on the
// end of the burst replays the buffer as round(127*x/peak) int8 results.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on the s_ channel, one request per cycle while s_tready
//   is high, with s_tlast on the final sample of a burst. Each sample is
//   written into the buffer memory and folded into the running peak.
//   Samples beyond BUFFER_DEPTH are dropped and mark every result of that
//   burst through m_tuser. When the last sample is accepted, s_tready drops
//   and the block reads the buffer back, one entry per cycle while the
//   output does not stall, N entries in all (N = buffered samples). Reads
//   feed a magnitude stage and a 7-stage pipelined quotient unit ahead of
//   the output register; results leave one per cycle while m_tready stays
//   high, the last one with m_tlast. The input stays held off until the
//   read-back pass over the single memory read port is done. s_tready
//   returns as soon as the last entry has been read, while the earlier
//   results still drain through the pipeline.
//   When m_tready is low while m_tvalid is high, the output register, the
//   quotient pipeline and the read-back hold in place; nothing is lost. Reset
//   clears the counters, the peak and all valid bits; the buffer needs no clearing.
// ----------------------------------------------------------------------------
module max_abs_int8_quantizer
    import mai8q_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Sample requests.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,  // [SAMPLE_WIDTH-1:0] sample
    input  logic                                 s_tlast,  // burst_end
    // Result requests.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [QOUT_W-1:0]                    m_tdata,  // [7:0] quantized
    output logic                                 m_tlast,  // result_last
    output logic                                 m_tuser   // overflowed
);

    localparam int IDX_W = idx_width(BUFFER_DEPTH);
    localparam int CNT_W = cnt_width(BUFFER_DEPTH);
    localparam int NUM_W = SAMPLE_WIDTH + QUOT_W;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [SAMPLE_WIDTH-1:0] peak_reg;
    logic                    ovf_reg;
    logic [IDX_W-1:0]        rd_idx_reg;

    // Read-back tag, aligned with the buffer's registered read data.
    logic                    rd_vld_reg;
    logic                    rd_last_reg;
    logic                    rd_ovf_reg;
    logic [SAMPLE_WIDTH-1:0] rd_pk_reg;

    // Magnitude stage in front of the quotient unit.
    logic                    pre_vld_reg;
    logic [NUM_W-1:0]        pre_num_reg;
    logic [SAMPLE_WIDTH-1:0] pre_pk_reg;
    div_tag_t                pre_tag_reg;

    // Output register.
    logic                    m_tvalid_reg;
    logic [QOUT_W-1:0]       m_tdata_reg;
    logic                    m_tlast_reg;
    logic                    m_tuser_reg;

    logic                    s_accept;
    logic                    buf_full;
    logic [SAMPLE_WIDTH-1:0] s_sample;
    logic [SAMPLE_WIDTH-1:0] s_mag;
    logic                    adv;
    logic                    issue;
    logic                    last_issue;
    logic [SAMPLE_WIDTH-1:0] rd_data;
    logic [SAMPLE_WIDTH-1:0] rd_mag;
    logic [NUM_W:0]          num_wide;
    logic                    div_vld;
    logic [QUOT_W-1:0]       div_quot;
    div_tag_t                div_tag;
    logic [QOUT_W-1:0]       q_mag;
    logic [QOUT_W-1:0]       q_signed;

    // Input side: the buffer accepts while it is being loaded.
    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign buf_full = (count_reg == CNT_W'(BUFFER_DEPTH));
    assign s_sample = s_tdata[SAMPLE_WIDTH-1:0];
    assign s_mag    = s_sample[SAMPLE_WIDTH-1] ? (~s_sample + 1'b1) : s_sample;

    // The whole read-back pipeline moves when the output register can take data.
    assign adv        = !m_tvalid_reg || m_tready;
    assign issue      = (state_reg == ST_EMIT) && adv;
    assign last_issue = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg;

    mai8q_buffer #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_buffer (
        .aclk    (aclk),
        .wr_en   (s_accept && !buf_full),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (s_sample),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    // Numerator of the rounded ratio: 2*127*|x| + peak.
    assign rd_mag   = rd_data[SAMPLE_WIDTH-1] ? (~rd_data + 1'b1) : rd_data;
    assign num_wide = (NUM_W+1)'(rd_mag) * (NUM_W+1)'(2 * QUANT_SCALE)
                    + (NUM_W+1)'(rd_pk_reg);

    mai8q_divider #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (pre_vld_reg),
        .in_num    (pre_num_reg),
        .in_peak   (pre_pk_reg),
        .in_tag    (pre_tag_reg),
        .out_valid (div_vld),
        .out_quot  (div_quot),
        .out_tag   (div_tag)
    );

    // Sign and all-zero handling of the finished quotient.
    assign q_mag    = QOUT_W'(div_quot);
    assign q_signed = div_tag.zero ? '0 : (div_tag.neg ? (~q_mag + 1'b1) : q_mag);

    // Control, accumulators, read-back sequencing and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            peak_reg     <= '0;
            ovf_reg      <= 1'b0;
            rd_idx_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            pre_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_accept) begin
                        if (buf_full) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            count_reg <= count_reg + 1'b1;
                            if (s_mag > peak_reg) begin
                                peak_reg <= s_mag;
                            end
                        end
                        if (s_tlast) begin
                            state_reg  <= ST_EMIT;
                            rd_idx_reg <= '0;
                        end
                    end
                end
                ST_EMIT: begin
                    if (issue) begin
                        rd_idx_reg  <= rd_idx_reg + 1'b1;
                        rd_last_reg <= last_issue;
                        rd_ovf_reg  <= ovf_reg;
                        rd_pk_reg   <= peak_reg;
                        if (last_issue) begin
                            state_reg <= ST_LOAD;
                            count_reg <= '0;
                            peak_reg  <= '0;
                            ovf_reg   <= 1'b0;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase

            if (adv) begin
                rd_vld_reg       <= issue;
                pre_vld_reg      <= rd_vld_reg;
                pre_num_reg      <= num_wide[NUM_W-1:0];
                pre_pk_reg       <= rd_pk_reg;
                pre_tag_reg.neg  <= rd_data[SAMPLE_WIDTH-1];
                pre_tag_reg.last <= rd_last_reg;
                pre_tag_reg.ovf  <= rd_ovf_reg;
                pre_tag_reg.zero <= (rd_pk_reg == '0);
                m_tvalid_reg     <= div_vld;
                m_tdata_reg      <= q_signed;
                m_tlast_reg      <= div_tag.last;
                m_tuser_reg      <= div_tag.ovf;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: sv/mai8q_checker.sv
// ----------------------------------------------------------------------------
// Max-abs int8 quantizer port checker
// Port-level assertions on the quantizer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mai8q_checker
    import mai8q_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [QOUT_W-1:0] m_tdata
);

    // Results are symmetric: the most negative int8 code never appears.
    a_no_min_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata != 8'h80))
        else $error("quantized result outside -127..127");

    // The end of a burst stops sample intake while the buffer is read back.
    a_tlast_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("sample accepted right after the end of a burst");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // Reset leaves the block empty and ready for samples.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("block not idle after reset");

endmodule

bind max_abs_int8_quantizer mai8q_checker u_mai8q_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
